@@ rtl/jdtamil_pkg.sv @@
// ----------------------------------------------------------------------------
// jdtamil_pkg
// Constants, codes and the month table shared by the Julian day to Tamil date
// converter and its checker.
// ----------------------------------------------------------------------------
package jdtamil_pkg;

    // Year estimate: floor((4*day + frac[15:14] - 4*J2000) / 1461), biased so
    // the dividend is never negative, then divided by a reciprocal multiply.
    localparam logic [5:0]  QP_BIAS     = 6'd52;          // 1461*6712 - 4*2451545
    localparam logic [25:0] YEAR_RECIP  = 26'd47035918;   // floor(2^36 / 1461)
    localparam int          RECIP_SHIFT = 36;
    localparam logic [10:0] DAYS_4YR    = 11'd1461;
    localparam logic [13:0] YEAR_BIAS   = 14'd6712;       // quotient bias, in years

    // Epoch day number, and the sidereal year in Q24
    localparam logic [21:0]        NEWYEAR_DAY  = 22'd2451649;
    localparam logic signed [33:0] SIDEREAL_Q24 = 34'sd6127984847;

    localparam logic signed [13:0] YEAR_BASE = 14'sd2000;
    localparam logic signed [13:0] YEAR_MIN  = 14'sd1;
    localparam logic signed [13:0] YEAR_MAX  = 14'sd4000;

    localparam logic [11:0] ERA_OFFSET = 12'd31;

    // Jovian cycle: ((year - 1987) mod 60) + 1 == ((year + 53) mod 60) + 1
    localparam logic [11:0] JOV_BIAS   = 12'd53;
    localparam logic [12:0] JOV_RECIP  = 13'd4369;        // floor(2^18 / 60)
    localparam int          JOV_SHIFT  = 18;
    localparam logic [11:0] JOV_LEN    = 12'd60;

    // Month numbers that matter for festivals and the negative-offset case
    localparam logic [3:0] MONTH_CHITTIRAI = 4'd1;
    localparam logic [3:0] MONTH_AIPPASI   = 4'd7;
    localparam logic [3:0] MONTH_THAI      = 4'd10;
    localparam logic [3:0] MONTH_PANGUNI   = 4'd12;
    localparam int         MONTH_COUNT     = 12;

    localparam logic [5:0] FEST_DAY_FIRST = 6'd1;
    localparam logic [5:0] FEST_DAY_MID   = 6'd15;
    localparam logic [5:0] DAY_MAX        = 6'd32;

    localparam logic [2:0] FEST_NONE      = 3'd0;
    localparam logic [2:0] FEST_NEW_YEAR  = 3'd1;
    localparam logic [2:0] FEST_PONGAL    = 3'd2;
    localparam logic [2:0] FEST_CHITHIRAI = 3'd3;
    localparam logic [2:0] FEST_DEEPAVALI = 3'd4;

    // Cumulative first-day offset of each month, index 0 is Chittirai.
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] v;
        case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd62;
            4'd3:    v = 9'd94;
            4'd4:    v = 9'd125;
            4'd5:    v = 9'd156;
            4'd6:    v = 9'd186;
            4'd7:    v = 9'd216;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/julian_day_to_tamil_date_top.sv @@
// Pipeline: 8 register stages, stage 0 (input register) to stage 7 (output register).
// Throughput: one item per clock; each stage holds only while the stage after it
// is full and stalled, so bubbles are squeezed out and s_ready stays high
// unless the whole pipe is backed up from m_ready.
// Reset: synchronous active-low aresetn clears all stage valid bits; data
// registers are not reset.
// ----------------------------------------------------------------------------
// julian_day_to_tamil_date_top
// Converts a Julian date (whole day + 16-bit fraction) to a Tamil solar date:
// Thiruvalluvar year, month, day, Jovian cycle index, festival code and a
// range flag, in Q24 fixed point.
// ----------------------------------------------------------------------------
module julian_day_to_tamil_date_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [21:0] s_jd_day,
    input  logic [15:0] s_jd_fraction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_era_year,
    output logic [3:0]  m_month,
    output logic [5:0]  m_day,
    output logic [5:0]  m_jovian_index,
    output logic [2:0]  m_festival,
    output logic        m_range_error
);
    import jdtamil_pkg::*;

    localparam int STAGES = 8;

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its successor loads.
    // ------------------------------------------------------------------
    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] adv;

    always_comb begin
        adv[STAGES-1] = !v_reg[STAGES-1] || m_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    assign s_ready = adv[0];
    assign m_valid = v_reg[STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (adv[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: input register
    // ------------------------------------------------------------------
    logic [21:0] day0_reg;
    logic [15:0] frac0_reg;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            day0_reg  <= s_jd_day;
            frac0_reg <= s_jd_fraction;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: biased quarter-day count and reciprocal multiply by 1/1461.
    // floor(4*rel/2^24) is just the day delta times four plus the top two
    // fraction bits; the bias keeps the dividend positive.
    // ------------------------------------------------------------------
    logic [24:0] qp1_next;
    logic [50:0] qprod;
    logic [13:0] qa1_next;
    logic [24:0] qp1_reg;
    logic [13:0] qa1_reg;
    logic [21:0] day1_reg;
    logic [15:0] frac1_reg;

    always_comb begin
        qp1_next = {1'b0, day0_reg, 2'b00} + {23'd0, frac0_reg[15:14]} + 25'(QP_BIAS);
        qprod    = 51'(qp1_next) * 51'(YEAR_RECIP);
        qa1_next = qprod[RECIP_SHIFT+13:RECIP_SHIFT];   // true quotient or one less
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            qp1_reg   <= qp1_next;
            qa1_reg   <= qa1_next;
            day1_reg  <= day0_reg;
            frac1_reg <= frac0_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: quotient correction -> year estimate relative to 2000;
    // Julian date relative to the new-year epoch in Q24.
    // ------------------------------------------------------------------
    logic [24:0]        qmul;
    logic [24:0]        qrem;
    logic [13:0]        qt;
    logic signed [13:0] ys2_next;
    logic signed [46:0] base2_next;
    logic signed [13:0] ys2_reg;
    logic signed [46:0] base2_reg;

    always_comb begin
        qmul       = 25'(qa1_reg) * 25'(DAYS_4YR);
        qrem       = qp1_reg - qmul;
        qt         = qa1_reg + 14'(qrem >= 25'(DAYS_4YR));
        ys2_next   = $signed(qt - YEAR_BIAS);
        base2_next = $signed({1'b0, day1_reg, frac1_reg, 8'd0})
                   - $signed({1'b0, NEWYEAR_DAY, 24'd0});
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            ys2_reg   <= ys2_next;
            base2_reg <= base2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: whole sidereal years since the epoch, in Q24
    // ------------------------------------------------------------------
    logic signed [47:0] prod3_next;
    logic signed [47:0] prod3_reg;
    logic signed [46:0] base3_reg;
    logic signed [13:0] ys3_reg;

    assign prod3_next = 48'(ys2_reg) * 48'(SIDEREAL_Q24);

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            prod3_reg <= prod3_next;
            base3_reg <= base2_reg;
            ys3_reg   <= ys2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: offset from the estimated year's new year, Q24
    // ------------------------------------------------------------------
    logic signed [48:0] d4_next;
    logic signed [48:0] d4_reg;
    logic signed [13:0] ys4_reg;

    assign d4_next = 49'(base3_reg) - 49'(prod3_reg);

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            d4_reg  <= d4_next;
            ys4_reg <= ys3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: year correction by one either way; whole-day offset
    // (arithmetic floor by 2^24, kept to 10 signed bits).
    // ------------------------------------------------------------------
    logic signed [48:0] d_minus;
    logic signed [48:0] d_plus;
    logic signed [48:0] offq;
    logic signed [13:0] yr5_next;
    logic signed [9:0]  off5_next;
    logic signed [13:0] yr5_reg;
    logic signed [9:0]  off5_reg;

    always_comb begin
        d_plus  = d4_reg + 49'(SIDEREAL_Q24);
        d_minus = d4_reg - 49'(SIDEREAL_Q24);
        if (d4_reg[48]) begin
            // before this year's new year: previous year
            offq     = d_plus;
            yr5_next = ys4_reg + YEAR_BASE - 14'sd1;
        end else if (!d_minus[48]) begin
            // at or past next new year
            offq     = d_minus;
            yr5_next = ys4_reg + YEAR_BASE + 14'sd1;
        end else begin
            offq     = d4_reg;
            yr5_next = ys4_reg + YEAR_BASE;
        end
        off5_next = offq[33:24];
    end

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            yr5_reg  <= yr5_next;
            off5_reg <= off5_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: range check, month lookup, day with clamp, era year,
    // Jovian quotient estimate.
    // ------------------------------------------------------------------
    logic               err6_next;
    logic [3:0]         month6_next;
    logic signed [10:0] day_s;
    logic [5:0]         day6_next;
    logic [11:0]        era6_next;
    logic [11:0]        jv6_next;
    logic [24:0]        jprod;
    logic [6:0]         jq6_next;

    logic               err6_reg;
    logic [3:0]         month6_reg;
    logic [5:0]         day6_reg;
    logic [11:0]        era6_reg;
    logic [11:0]        jv6_reg;
    logic [6:0]         jq6_reg;

    always_comb begin
        err6_next = (yr5_reg < YEAR_MIN) || (yr5_reg > YEAR_MAX);

        // negative offset falls through to the last month
        month6_next = MONTH_PANGUNI;
        for (int m = 0; m < MONTH_COUNT; m++) begin
            if (off5_reg >= $signed({1'b0, month_start(4'(m))})) begin
                month6_next = 4'(m + 1);
            end
        end

        day_s = 11'(off5_reg) - $signed({2'b00, month_start(month6_next - 4'd1)})
              + 11'sd1;
        if (day_s < 11'sd1) begin
            day6_next = FEST_DAY_FIRST;
        end else if (day_s > $signed({5'd0, DAY_MAX})) begin
            day6_next = DAY_MAX;
        end else begin
            day6_next = day_s[5:0];
        end

        era6_next = 12'(yr5_reg) + ERA_OFFSET;
        jv6_next  = 12'(yr5_reg) + JOV_BIAS;
        jprod     = 25'(jv6_next) * 25'(JOV_RECIP);
        jq6_next  = jprod[JOV_SHIFT+6:JOV_SHIFT];      // true quotient or one less
    end

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            err6_reg   <= err6_next;
            month6_reg <= month6_next;
            day6_reg   <= day6_next;
            era6_reg   <= era6_next;
            jv6_reg    <= jv6_next;
            jq6_reg    <= jq6_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: output register. Jovian remainder, festival code, and
    // zeroing of all fields on a range error.
    // ------------------------------------------------------------------
    logic [11:0] jrem;
    logic [11:0] jrem_fix;
    logic [2:0]  fest;

    logic [11:0] era7_next;
    logic [3:0]  month7_next;
    logic [5:0]  day7_next;
    logic [5:0]  jov7_next;
    logic [2:0]  fest7_next;

    logic [11:0] era7_reg;
    logic [3:0]  month7_reg;
    logic [5:0]  day7_reg;
    logic [5:0]  jov7_reg;
    logic [2:0]  fest7_reg;
    logic        err7_reg;

    always_comb begin
        jrem     = jv6_reg - 12'(12'(jq6_reg) * JOV_LEN);
        jrem_fix = (jrem >= JOV_LEN) ? (jrem - JOV_LEN) : jrem;

        if (month6_reg == MONTH_CHITTIRAI && day6_reg == FEST_DAY_FIRST) begin
            fest = FEST_NEW_YEAR;
        end else if (month6_reg == MONTH_CHITTIRAI && day6_reg == FEST_DAY_MID) begin
            fest = FEST_CHITHIRAI;
        end else if (month6_reg == MONTH_AIPPASI && day6_reg == FEST_DAY_MID) begin
            fest = FEST_DEEPAVALI;
        end else if (month6_reg == MONTH_THAI && day6_reg == FEST_DAY_FIRST) begin
            fest = FEST_PONGAL;
        end else begin
            fest = FEST_NONE;
        end

        if (err6_reg) begin
            era7_next   = '0;
            month7_next = '0;
            day7_next   = '0;
            jov7_next   = '0;
            fest7_next  = FEST_NONE;
        end else begin
            era7_next   = era6_reg;
            month7_next = month6_reg;
            day7_next   = day6_reg;
            jov7_next   = jrem_fix[5:0] + 6'd1;
            fest7_next  = fest;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[7]) begin
            era7_reg   <= era7_next;
            month7_reg <= month7_next;
            day7_reg   <= day7_next;
            jov7_reg   <= jov7_next;
            fest7_reg  <= fest7_next;
            err7_reg   <= err6_reg;
        end
    end

    assign m_era_year     = era7_reg;
    assign m_month        = month7_reg;
    assign m_day          = day7_reg;
    assign m_jovian_index = jov7_reg;
    assign m_festival     = fest7_reg;
    assign m_range_error  = err7_reg;

endmodule

@@ rtl/jdtamil_check.sv @@
// ----------------------------------------------------------------------------
// jdtamil_check
// Port-level checks for the Julian day to Tamil date converter, bound to the
// top level.
// ----------------------------------------------------------------------------
module jdtamil_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [21:0] s_jd_day,
    input logic [15:0] s_jd_fraction,
    input logic        m_valid,
    input logic        m_ready,
    input logic [11:0] m_era_year,
    input logic [3:0]  m_month,
    input logic [5:0]  m_day,
    input logic [5:0]  m_jovian_index,
    input logic [2:0]  m_festival,
    input logic        m_range_error
);
    import jdtamil_pkg::*;

    // no result item straight out of reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_era_year) && $stable(m_month)
            && $stable(m_day) && $stable(m_jovian_index) && $stable(m_festival)
            && $stable(m_range_error))
        else $error("stalled result changed");

    // out-of-range item carries all-zero fields
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_error |-> m_era_year == 12'd0 && m_month == 4'd0
            && m_day == 6'd0 && m_jovian_index == 6'd0 && m_festival == FEST_NONE)
        else $error("range error with nonzero fields");

    // in-range item stays within calendar limits
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_range_error |-> m_month >= MONTH_CHITTIRAI
            && m_month <= MONTH_PANGUNI && m_day >= FEST_DAY_FIRST && m_day <= DAY_MAX
            && m_jovian_index >= 6'd1 && m_jovian_index <= 6'd60
            && m_era_year >= 12'd32 && m_era_year <= 12'd4031)
        else $error("result field out of range");

    // festivals only on their days
    a_festival: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_festival != FEST_NONE |->
            (m_day == FEST_DAY_FIRST || m_day == FEST_DAY_MID)
            && (m_month == MONTH_CHITTIRAI || m_month == MONTH_AIPPASI
                || m_month == MONTH_THAI))
        else $error("festival code on a wrong date");

endmodule

bind julian_day_to_tamil_date_top jdtamil_check u_jdtamil_check (.*);
